@@ src/lcm_pkg.sv @@
// Shared types and constants for the least common multiple unit.
// Used by lcm_ctrl, lcm_dp and lcm_two_operands_unit; depends on nothing.
package lcm_pkg;

    localparam int IN_WIDTH       = 32;
    localparam int MULTIPLE_WIDTH = 64;

    typedef struct packed {
        logic load;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic mul_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic zero;
        logic gcd_done;
    } t_sts;

endpackage

@@ src/lcm_dp.sv @@
// Datapath: binary GCD reduction, restoring divider and shift-add multiplier.
// Depends on lcm_pkg; driven by commands from lcm_ctrl.
module lcm_dp #(
    parameter int W = 32
) (
    input  logic                                 i_clk,
    input  logic [lcm_pkg::IN_WIDTH-1:0]         i_operand_a,
    input  logic [lcm_pkg::IN_WIDTH-1:0]         i_operand_b,
    input  lcm_pkg::t_cmd                        i_cmd,
    output lcm_pkg::t_sts                        o_sts,
    output logic [lcm_pkg::MULTIPLE_WIDTH-1:0]   o_multiple
);
    import lcm_pkg::*;

    logic [W-1:0]   r_x, n_x;
    logic [W-1:0]   r_y, n_y;
    logic [W-1:0]   r_a, n_a;
    logic [W-1:0]   r_b, n_b;
    logic [W-1:0]   r_rem, n_rem;
    logic [W-1:0]   r_quo, n_quo;
    logic [W-1:0]   r_hi, n_hi;
    logic [2*W-1:0] r_multiple, n_multiple;

    logic [W-1:0]   in_a;
    logic [W-1:0]   in_b;
    logic [W-1:0]   diff_xy;
    logic [W-1:0]   diff_yx;
    logic [W:0]     trial;
    logic [W:0]     trial_sub;
    logic           trial_ge;
    logic [W:0]     mul_sum;

    assign in_a      = i_operand_a[W-1:0];
    assign in_b      = i_operand_b[W-1:0];
    assign diff_xy   = r_x - r_y;
    assign diff_yx   = r_y - r_x;
    assign trial     = {r_rem, r_quo[W-1]};
    assign trial_sub = trial - {1'b0, r_x};
    assign trial_ge  = (trial >= {1'b0, r_x});
    assign mul_sum   = {1'b0, r_hi} + (r_quo[0] ? {1'b0, r_b} : {(W+1){1'b0}});

    assign o_sts.zero     = (in_a == '0) || (in_b == '0);
    assign o_sts.gcd_done = (r_x == r_y);
    assign o_multiple     = MULTIPLE_WIDTH'(r_multiple);

    always_comb begin
        n_x        = r_x;
        n_y        = r_y;
        n_a        = r_a;
        n_b        = r_b;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_hi       = r_hi;
        n_multiple = r_multiple;
        if (i_cmd.load) begin
            n_x   = in_a;
            n_y   = in_b;
            n_a   = in_a;
            n_b   = in_b;
            n_rem = '0;
            n_quo = '0;
            n_hi  = '0;
        end
        if (i_cmd.gcd_step) begin
            if (!r_x[0] && !r_y[0]) begin
                n_x = r_x >> 1;
                n_y = r_y >> 1;
                n_a = r_a >> 1;
            end else if (!r_x[0]) begin
                n_x = r_x >> 1;
            end else if (!r_y[0]) begin
                n_y = r_y >> 1;
            end else if (r_x > r_y) begin
                n_x = diff_xy >> 1;
            end else begin
                n_y = diff_yx >> 1;
            end
        end
        if (i_cmd.div_init) begin
            n_quo = r_a;
        end
        if (i_cmd.div_step) begin
            n_rem = trial_ge ? trial_sub[W-1:0] : trial[W-1:0];
            n_quo = {r_quo[W-2:0], trial_ge};
        end
        if (i_cmd.mul_step) begin
            n_hi  = mul_sum[W:1];
            n_quo = {mul_sum[0], r_quo[W-1:1]};
        end
        if (i_cmd.out_load) begin
            n_multiple = {r_hi, r_quo};
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_y        <= n_y;
        r_a        <= n_a;
        r_b        <= n_b;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_hi       <= n_hi;
        r_multiple <= n_multiple;
    end

endmodule

@@ src/lcm_ctrl.sv @@
// Controller: sequences load, GCD, divide and multiply phases and owns the handshakes.
// Depends on lcm_pkg; drives lcm_dp through t_cmd and reads t_sts.
module lcm_ctrl #(
    parameter int W = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  lcm_pkg::t_sts i_sts,
    output lcm_pkg::t_cmd o_cmd
);
    import lcm_pkg::*;

    localparam int CW = (W > 1) ? $clog2(W) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GCD  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_HOLD = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;
    logic          cnt_last;
    logic          slot_free;

    assign cnt_last  = (r_cnt == CW'(W - 1));
    assign slot_free = !r_out_valid || !i_stall;
    assign o_stall   = (r_state != S_IDLE);
    assign o_valid   = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.zero ? S_HOLD : S_GCD;
                end
            end
            S_GCD: begin
                if (i_sts.gcd_done) begin
                    o_cmd.div_init = 1'b1;
                    n_cnt          = '0;
                    n_state        = S_DIV;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (cnt_last) begin
                    n_cnt   = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (cnt_last) begin
                    n_cnt   = '0;
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef ASSERT_OFF
    a_load_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || !i_stall))
        else $error("result loaded over a pending beat");

    a_zero_skips_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid && i_sts.zero) |=> (r_state == S_HOLD))
        else $error("zero operand did not go straight to output");

    a_div_starts_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GCD && i_sts.gcd_done) |=> (r_state == S_DIV && r_cnt == '0))
        else $error("divide phase entered with stale count");

    a_out_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && cnt_last) |=> (r_state == S_HOLD))
        else $error("multiply phase overran");
`endif

endmodule

@@ src/lcm_two_operands_unit.sv @@
// Least common multiple of two unsigned operands, one item at a time.
// Sequence: a load step, GCD steps and an exit step, OPERAND_WIDTH divide steps,
// OPERAND_WIDTH multiply steps, then an output step. A zero operand goes from the load step
// straight to the output step. No new item is taken until the shared GCD, divide and multiply
// sequence is done; the result register frees the input while a beat waits.
// Reset clears the controller and output valid only; no clearing pass is needed.
module lcm_two_operands_unit #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [lcm_pkg::IN_WIDTH-1:0]         i_operand_a,
    input  logic [lcm_pkg::IN_WIDTH-1:0]         i_operand_b,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [lcm_pkg::MULTIPLE_WIDTH-1:0]   o_multiple
);
    import lcm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    lcm_ctrl #(
        .W (OPERAND_WIDTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    lcm_dp #(
        .W (OPERAND_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_multiple  (o_multiple)
    );

endmodule
